// File: rtl/core/cil_pkg.sv
// shared types, codes and helper functions of the integer literal classifier
`default_nettype none

package cil_pkg;

  typedef struct packed {
    logic [7:0] character;
    logic       is_last;
  } cil_in_t;

  typedef struct packed {
    logic        literal_valid;
    logic [2:0]  type_code;
    logic [63:0] literal_value;
  } cil_out_t;

  typedef enum logic [3:0] {
    PH_START  = 4'd0,
    PH_ZERO   = 4'd1,
    PH_ZX     = 4'd2,
    PH_ZB     = 4'd3,
    PH_DIGITS = 4'd4,
    PH_SUFFIX = 4'd5
  } phase_t;

  typedef enum logic [1:0] {
    BASE_DEC = 2'd0,
    BASE_HEX = 2'd1,
    BASE_OCT = 2'd2,
    BASE_BIN = 2'd3
  } base_t;

  // suffix spellings seen so far
  typedef enum logic [3:0] {
    SFX_NONE   = 4'd0,
    SFX_UP_L   = 4'd1,
    SFX_LO_L   = 4'd2,
    SFX_LL     = 4'd3,
    SFX_LU     = 4'd4,
    SFX_LLU    = 4'd5,
    SFX_U      = 4'd6,
    SFX_U_UP_L = 4'd7,
    SFX_U_LO_L = 4'd8,
    SFX_ULL    = 4'd9
  } sfx_t;

  localparam logic [2:0] TY_INT    = 3'd0;
  localparam logic [2:0] TY_UINT   = 3'd1;
  localparam logic [2:0] TY_LONG   = 3'd2;
  localparam logic [2:0] TY_ULONG  = 3'd3;
  localparam logic [2:0] TY_LLONG  = 3'd4;
  localparam logic [2:0] TY_ULLONG = 3'd5;

  // finished literal handed from the parser to the classifier
  typedef struct packed {
    logic        ok;
    logic        is_dec;
    sfx_t        suffix;
    logic [63:0] value;
  } cil_fin_t;

  // {is a hex digit, digit value}
  function automatic logic [4:0] digit_of(input logic [7:0] ch);
    logic [4:0] r;
    r = 5'd0;
    if (ch >= "0" && ch <= "9") begin
      r = {1'b1, 4'(ch - "0")};
    end else if (ch >= "a" && ch <= "f") begin
      r = {1'b1, 4'(ch - "a" + 8'd10)};
    end else if (ch >= "A" && ch <= "F") begin
      r = {1'b1, 4'(ch - "A" + 8'd10)};
    end
    return r;
  endfunction

  // digit value below the radix of the base
  function automatic logic digit_fits(input logic [3:0] val, input base_t b);
    logic r;
    unique case (b)
      BASE_DEC: r = val < 4'd10;
      BASE_HEX: r = 1'b1;
      BASE_OCT: r = val < 4'd8;
      BASE_BIN: r = val < 4'd2;
      default:  r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/cil_parser.sv
// character parser: base detection, saturating accumulate and suffix match
`default_nettype none

module cil_parser
  import cil_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     item_valid,
  input  wire cil_in_t  item,
  output logic          consume,
  output logic          fin_valid,
  input  wire logic     fin_ready,
  output cil_fin_t      fin
);

  phase_t      phase, phase_next;
  base_t       base, base_next;
  logic [63:0] acc, acc_next;
  logic        ovf, ovf_next;
  sfx_t        sfx, sfx_next;
  logic        err, err_next;

  logic        parse_err;
  logic        acc_en;
  base_t       acc_base;
  base_t       pfx_base;
  logic        sfx_en;
  logic [4:0]  dig;
  logic [67:0] prod;
  logic [4:0]  sfx_step;
  logic        ok;

  assign dig = digit_of(item.character);

  // next suffix state, bit 4 flags a spelling that is not accepted
  function automatic logic [4:0] suffix_feed(input sfx_t s, input logic [7:0] ch);
    logic up_l, lo_l, is_u;
    logic [4:0] r;
    up_l = ch == "L";
    lo_l = ch == "l";
    is_u = ch == "U" || ch == "u";
    r = {1'b1, SFX_NONE};
    unique case (s)
      SFX_NONE: begin
        if (up_l)      r = {1'b0, SFX_UP_L};
        else if (lo_l) r = {1'b0, SFX_LO_L};
        else if (is_u) r = {1'b0, SFX_U};
      end
      SFX_UP_L: begin
        if (up_l)      r = {1'b0, SFX_LL};
        else if (is_u) r = {1'b0, SFX_LU};
      end
      SFX_LO_L: begin
        if (lo_l)      r = {1'b0, SFX_LL};
        else if (is_u) r = {1'b0, SFX_LU};
      end
      SFX_LL:     if (is_u) r = {1'b0, SFX_LLU};
      SFX_U: begin
        if (up_l)      r = {1'b0, SFX_U_UP_L};
        else if (lo_l) r = {1'b0, SFX_U_LO_L};
      end
      SFX_U_UP_L: if (up_l) r = {1'b0, SFX_ULL};
      SFX_U_LO_L: if (lo_l) r = {1'b0, SFX_ULL};
      default:    r = {1'b1, SFX_NONE};
    endcase
    return r;
  endfunction

  // phase step
  always_comb begin
    phase_next = phase;
    base_next  = base;
    parse_err  = 1'b0;
    acc_en     = 1'b0;
    acc_base   = base;
    sfx_en     = 1'b0;
    pfx_base   = (phase == PH_ZX) ? BASE_HEX : BASE_BIN;
    if (!err) begin
      unique case (phase)
        PH_START: begin
          if (item.character == "0") begin
            phase_next = PH_ZERO;
            base_next  = BASE_OCT;
          end else if (item.character >= "1" && item.character <= "9") begin
            base_next  = BASE_DEC;
            acc_en     = 1'b1;
            acc_base   = BASE_DEC;
            phase_next = PH_DIGITS;
          end else begin
            parse_err = 1'b1;
          end
        end
        PH_ZERO: begin
          if (item.character == "x" || item.character == "X") begin
            phase_next = PH_ZX;
          end else if (item.character == "b" || item.character == "B") begin
            phase_next = PH_ZB;
          end else if (dig[4] && digit_fits(dig[3:0], BASE_OCT)) begin
            acc_en     = 1'b1;
            acc_base   = BASE_OCT;
            phase_next = PH_DIGITS;
          end else begin
            phase_next = PH_SUFFIX;
            sfx_en     = 1'b1;
          end
        end
        PH_ZX, PH_ZB: begin
          if (dig[4] && digit_fits(dig[3:0], pfx_base)) begin
            base_next  = pfx_base;
            acc_en     = 1'b1;
            acc_base   = pfx_base;
            phase_next = PH_DIGITS;
          end else begin
            parse_err = 1'b1;
          end
        end
        PH_DIGITS: begin
          if (dig[4] && digit_fits(dig[3:0], base)) begin
            acc_en = 1'b1;
          end else begin
            phase_next = PH_SUFFIX;
            sfx_en     = 1'b1;
          end
        end
        PH_SUFFIX: sfx_en = 1'b1;
        default:   parse_err = 1'b1;
      endcase
    end
  end

  // accumulate: value times radix plus digit, as shifts and adds
  always_comb begin
    unique case (acc_base)
      BASE_DEC: prod = {3'b0, acc, 1'b0} + {1'b0, acc, 3'b0} + 68'(dig[3:0]);
      BASE_HEX: prod = {acc, 4'b0} + 68'(dig[3:0]);
      BASE_OCT: prod = {1'b0, acc, 3'b0} + 68'(dig[3:0]);
      BASE_BIN: prod = {3'b0, acc, 1'b0} + 68'(dig[3:0]);
      default:  prod = '0;
    endcase
  end

  always_comb begin
    acc_next = acc;
    ovf_next = ovf;
    if (acc_en && !ovf) begin
      if (prod[67:64] != 4'd0) begin
        ovf_next = 1'b1;
        acc_next = '1;
      end else begin
        acc_next = prod[63:0];
      end
    end
  end

  assign sfx_step = suffix_feed(sfx, item.character);
  assign sfx_next = (sfx_en && !sfx_step[4]) ? sfx_t'(sfx_step[3:0]) : sfx;
  assign err_next = err | parse_err | (sfx_en & sfx_step[4]);

  assign ok = !err_next
           && (phase_next == PH_ZERO || phase_next == PH_DIGITS || phase_next == PH_SUFFIX)
           && sfx_next != SFX_U_UP_L && sfx_next != SFX_U_LO_L;

  // a last character waits only when the finish register cannot move on
  assign consume = item_valid && (!item.is_last || !fin_valid || fin_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
      base  <= BASE_DEC;
      acc   <= '0;
      ovf   <= 1'b0;
      sfx   <= SFX_NONE;
      err   <= 1'b0;
    end else if (consume) begin
      if (item.is_last) begin
        phase <= PH_START;
        base  <= BASE_DEC;
        acc   <= '0;
        ovf   <= 1'b0;
        sfx   <= SFX_NONE;
        err   <= 1'b0;
      end else begin
        phase <= phase_next;
        base  <= base_next;
        acc   <= acc_next;
        ovf   <= ovf_next;
        sfx   <= sfx_next;
        err   <= err_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else begin
      fin_valid <= (consume && item.is_last) || (fin_valid && !fin_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (consume && item.is_last) begin
      fin.ok     <= ok;
      fin.is_dec <= base_next == BASE_DEC;
      fin.suffix <= sfx_next;
      fin.value  <= acc_next;
    end
  end

  a_ovf_saturates: assert property (@(posedge clk) disable iff (rst)
    ovf |-> acc == '1)
    else $error("overflow flag set but value not saturated");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (consume && item.is_last) |=> (phase == PH_START && !err && !ovf
                                    && acc == '0 && sfx == SFX_NONE))
    else $error("parse state not cleared after last character");

  a_fin_holds: assert property (@(posedge clk) disable iff (rst)
    (fin_valid && !fin_ready) |=> (fin_valid && $stable(fin)))
    else $error("finished literal lost while stalled");

endmodule

`default_nettype wire

// File: rtl/core/cil_classify.sv
// type selection by the promotion rules and the result register
`default_nettype none

module cil_classify
  import cil_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     long_is_64_bit,
  input  wire logic     fin_valid,
  output logic          fin_ready,
  input  wire cil_fin_t fin,
  output logic          out_valid,
  input  wire logic     out_ready,
  output cil_out_t      out_data
);

  logic       le_int, le_uint, le_llong, le_long, le_ulong;
  logic [2:0] ty;
  cil_out_t   res;

  assign le_int   = fin.value[63:31] == '0;
  assign le_uint  = fin.value[63:32] == '0;
  assign le_llong = !fin.value[63];
  assign le_long  = long_is_64_bit ? le_llong : le_int;
  assign le_ulong = long_is_64_bit ? 1'b1 : le_uint;

  always_comb begin
    unique case (fin.suffix)
      SFX_LLU, SFX_ULL: ty = TY_ULLONG;
      SFX_LL:           ty = (fin.is_dec || le_llong) ? TY_LLONG : TY_ULLONG;
      SFX_LU:           ty = le_ulong ? TY_ULONG : TY_ULLONG;
      SFX_UP_L, SFX_LO_L: begin
        priority if (le_long)    ty = TY_LONG;
        else if (fin.is_dec)     ty = TY_LLONG;
        else if (le_ulong)       ty = TY_ULONG;
        else if (le_llong)       ty = TY_LLONG;
        else                     ty = TY_ULLONG;
      end
      SFX_U: begin
        priority if (le_uint)    ty = TY_UINT;
        else if (le_ulong)       ty = TY_ULONG;
        else                     ty = TY_ULLONG;
      end
      default: begin
        priority if (le_int)     ty = TY_INT;
        else if (fin.is_dec)     ty = le_long ? TY_LONG : TY_LLONG;
        else if (le_uint)        ty = TY_UINT;
        else if (le_long)        ty = TY_LONG;
        else if (le_ulong)       ty = TY_ULONG;
        else if (le_llong)       ty = TY_LLONG;
        else                     ty = TY_ULLONG;
      end
    endcase
  end

  always_comb begin
    if (fin.ok) begin
      res.literal_valid = 1'b1;
      res.type_code     = ty;
      res.literal_value = fin.value;
    end else begin
      res = '0;
    end
  end

  assign fin_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_ready) begin
      out_valid <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_valid && fin_ready) begin
      out_data <= res;
    end
  end

  a_invalid_is_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.literal_valid)
      |-> (out_data.type_code == TY_INT && out_data.literal_value == '0))
    else $error("invalid literal with nonzero type or value");

  a_type_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.type_code <= TY_ULLONG)
    else $error("type code out of range");

  a_fin_taken: assert property (@(posedge clk) disable iff (rst)
    (fin_valid && fin_ready) |=> out_valid)
    else $error("finished literal did not reach the result register");

endmodule

`default_nettype wire

// File: rtl/core/c_integer_literal_classifier.sv
// top level of the C integer literal classifier
`default_nettype none

// Reads the text of a C integer literal one character per item, is_last
// marking the final one, and gives one result item per literal: validity,
// C type code and 64-bit value (all ones when it overflowed). Characters
// after the last mark start a new literal. One character is taken every
// cycle unless a last character waits on a stalled finish register; the
// whole per-character step (digit decode, value times radix plus digit as
// a shift-and-add, suffix match) sits between the input register and the
// parse state. Up to three literals can be in flight (input register,
// finish register, result register), so a stalled output does not stop
// input until those fill. cfg_data sets long to 64 bits (1, reset value)
// or 32 bits (0); write it only while no literal is in progress.
// cfg_ready is always high.

module c_integer_literal_classifier
  import cil_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  // character items
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire cil_in_t in_data,
  // result items
  output logic         out_valid,
  input  wire logic    out_ready,
  output cil_out_t     out_data,
  // long width register
  input  wire logic    cfg_valid,
  output logic         cfg_ready,
  input  wire logic    cfg_data
);

  logic     long_is_64_bit;
  logic     item_valid;
  cil_in_t  item;
  logic     consume;
  logic     fin_valid;
  logic     fin_ready;
  cil_fin_t fin;

  // config register, taken in any cycle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_is_64_bit <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      long_is_64_bit <= cfg_data;
    end
  end

  // input register, refilled in the same cycle its item moves on
  assign in_ready = !item_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_data;
    end
  end

  // per-character parse state and finish register
  cil_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .consume    (consume),
    .fin_valid  (fin_valid),
    .fin_ready  (fin_ready),
    .fin        (fin)
  );

  // type choice and result register
  cil_classify u_classify (
    .clk            (clk),
    .rst            (rst),
    .long_is_64_bit (long_is_64_bit),
    .fin_valid      (fin_valid),
    .fin_ready      (fin_ready),
    .fin            (fin),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data)
  );

endmodule

`default_nettype wire

// File: test/tb_c_integer_literal_classifier.sv
`timescale 1ns / 100ps
// testbench for the C integer literal classifier: directed and random literals, parser model
module tb_c_integer_literal_classifier;
  import cil_pkg::*;

  // limits of the C integer types
  localparam logic [63:0] MAX_INT32  = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] MAX_UINT32 = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] MAX_INT64  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MAX_UINT64 = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef byte unsigned text_t[$];

  // mirrors the parse of one literal and holds the results still due
  class literal_scoreboard;
    phase_t      phase;
    base_t       base;
    logic [63:0] acc;
    bit          overflowed;
    sfx_t        sfx;
    bit          failed;
    bit          long_wide;
    cil_out_t    expected_literals[$];
    int          errors;
    int          checked;

    function new();
      long_wide = 1'b1;
      errors = 0;
      checked = 0;
      restart_literal();
    endfunction

    function void restart_literal();
      phase = PH_START;
      base = BASE_DEC;
      acc = '0;
      overflowed = 1'b0;
      sfx = SFX_NONE;
      failed = 1'b0;
    endfunction

    function void set_long_width(logic wide);
      long_wide = wide;
    endfunction

    function int pending();
      return expected_literals.size();
    endfunction

    task report(string msg);
      $display("ERROR %0t: %s", $time, msg);
      errors++;
    endtask

    function int base_radix();
      case (base)
        BASE_HEX: return 16;
        BASE_OCT: return 8;
        BASE_BIN: return 2;
        default:  return 10;
      endcase
    endfunction

    // digit value, or -1 when the character is no digit of that radix
    function int digit_value(logic [7:0] ch, int radix);
      int d;
      if (ch >= "0" && ch <= "9") d = int'(ch - "0");
      else if (ch >= "a" && ch <= "f") d = int'(ch - "a") + 10;
      else if (ch >= "A" && ch <= "F") d = int'(ch - "A") + 10;
      else d = -1;
      if (d >= radix) d = -1;
      return d;
    endfunction

    // value times radix plus digit, sticking at all ones once it overflows
    function void accumulate(int d);
      logic [63:0] r;
      logic [63:0] dv;
      r = 64'(base_radix());
      dv = 64'(d);
      if (overflowed) return;
      if (acc > (MAX_UINT64 - dv) / r) begin
        overflowed = 1'b1;
        acc = MAX_UINT64;
      end else begin
        acc = acc * r + dv;
      end
    endfunction

    function void feed_suffix(logic [7:0] ch);
      bit up_l;
      bit lo_l;
      bit is_u;
      bit moved;
      up_l = (ch == "L");
      lo_l = (ch == "l");
      is_u = (ch == "U" || ch == "u");
      moved = 1'b1;
      case (sfx)
        SFX_NONE: begin
          if (up_l) sfx = SFX_UP_L;
          else if (lo_l) sfx = SFX_LO_L;
          else if (is_u) sfx = SFX_U;
          else moved = 1'b0;
        end
        SFX_UP_L: begin
          if (up_l) sfx = SFX_LL;
          else if (is_u) sfx = SFX_LU;
          else moved = 1'b0;
        end
        SFX_LO_L: begin
          if (lo_l) sfx = SFX_LL;
          else if (is_u) sfx = SFX_LU;
          else moved = 1'b0;
        end
        SFX_LL: begin
          if (is_u) sfx = SFX_LLU;
          else moved = 1'b0;
        end
        SFX_U: begin
          if (up_l) sfx = SFX_U_UP_L;
          else if (lo_l) sfx = SFX_U_LO_L;
          else moved = 1'b0;
        end
        SFX_U_UP_L: begin
          if (up_l) sfx = SFX_ULL;
          else moved = 1'b0;
        end
        SFX_U_LO_L: begin
          if (lo_l) sfx = SFX_ULL;
          else moved = 1'b0;
        end
        default: moved = 1'b0;
      endcase
      if (!moved) failed = 1'b1;
    endfunction

    function void parse_char(logic [7:0] ch);
      int d;
      case (phase)
        PH_START: begin
          if (ch == "0") begin
            phase = PH_ZERO;
            base = BASE_OCT;
          end else if (ch >= "1" && ch <= "9") begin
            base = BASE_DEC;
            accumulate(int'(ch - "0"));
            phase = PH_DIGITS;
          end else begin
            failed = 1'b1;
          end
        end
        PH_ZERO: begin
          d = digit_value(ch, 8);
          if (ch == "x" || ch == "X") begin
            phase = PH_ZX;
          end else if (ch == "b" || ch == "B") begin
            phase = PH_ZB;
          end else if (d >= 0) begin
            accumulate(d);
            phase = PH_DIGITS;
          end else begin
            phase = PH_SUFFIX;
            feed_suffix(ch);
          end
        end
        PH_ZX: begin
          d = digit_value(ch, 16);
          if (d < 0) begin
            failed = 1'b1;
          end else begin
            base = BASE_HEX;
            accumulate(d);
            phase = PH_DIGITS;
          end
        end
        PH_ZB: begin
          d = digit_value(ch, 2);
          if (d < 0) begin
            failed = 1'b1;
          end else begin
            base = BASE_BIN;
            accumulate(d);
            phase = PH_DIGITS;
          end
        end
        PH_DIGITS: begin
          d = digit_value(ch, base_radix());
          if (d >= 0) begin
            accumulate(d);
          end else begin
            phase = PH_SUFFIX;
            feed_suffix(ch);
          end
        end
        PH_SUFFIX: feed_suffix(ch);
        default: failed = 1'b1;
      endcase
    endfunction

    // C promotion rules for the value and the suffix seen
    function logic [2:0] choose_type(logic [63:0] v);
      logic [63:0] signed_long_lim;
      logic [63:0] unsigned_long_lim;
      bit dec;
      signed_long_lim = long_wide ? MAX_INT64 : MAX_INT32;
      unsigned_long_lim = long_wide ? MAX_UINT64 : MAX_UINT32;
      dec = (base == BASE_DEC);
      case (sfx)
        SFX_LLU, SFX_ULL: return TY_ULLONG;
        SFX_LL: return (dec || v <= MAX_INT64) ? TY_LLONG : TY_ULLONG;
        SFX_LU: return (v <= unsigned_long_lim) ? TY_ULONG : TY_ULLONG;
        SFX_UP_L, SFX_LO_L: begin
          if (v <= signed_long_lim) return TY_LONG;
          if (dec) return TY_LLONG;
          if (v <= unsigned_long_lim) return TY_ULONG;
          return (v <= MAX_INT64) ? TY_LLONG : TY_ULLONG;
        end
        SFX_U: begin
          if (v <= MAX_UINT32) return TY_UINT;
          return (v <= unsigned_long_lim) ? TY_ULONG : TY_ULLONG;
        end
        default: begin
          if (v <= MAX_INT32) return TY_INT;
          if (dec) return (v <= signed_long_lim) ? TY_LONG : TY_LLONG;
          if (v <= MAX_UINT32) return TY_UINT;
          if (v <= signed_long_lim) return TY_LONG;
          if (v <= unsigned_long_lim) return TY_ULONG;
          return (v <= MAX_INT64) ? TY_LLONG : TY_ULLONG;
        end
      endcase
    endfunction

    function void note_char(cil_in_t it);
      cil_out_t e;
      bit good;
      if (!failed) parse_char(it.character);
      if (it.is_last) begin
        good = !failed && (phase == PH_ZERO || phase == PH_DIGITS || phase == PH_SUFFIX)
               && sfx != SFX_U_UP_L && sfx != SFX_U_LO_L;
        e = '0;
        if (good) begin
          e.literal_valid = 1'b1;
          e.type_code = choose_type(acc);
          e.literal_value = acc;
        end
        expected_literals.push_back(e);
        restart_literal();
      end
    endfunction

    task check_literal(cil_out_t got);
      cil_out_t want;
      if (expected_literals.size() == 0) begin
        report($sformatf("result with no literal pending: valid %0b type %0d value %h",
                         got.literal_valid, got.type_code, got.literal_value));
        return;
      end
      want = expected_literals.pop_front();
      checked++;
      if (got.literal_valid !== want.literal_valid || got.type_code !== want.type_code ||
          got.literal_value !== want.literal_value)
        report($sformatf("literal %0d: got valid %0b type %0d value %h, want %0b %0d %h",
                         checked, got.literal_valid, got.type_code, got.literal_value,
                         want.literal_valid, want.type_code, want.literal_value));
    endtask
  endclass

  // clock, reset and block ports, the driven ones known from time zero
  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_ready;
  cil_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  cil_out_t out_data;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  logic     cfg_data = 1'b0;

  // idling of each side in percent per cycle
  int idle_pct = 0;
  int stall_pct = 0;
  int chars_sent = 0;

  literal_scoreboard board = new();

  // values around the type boundaries, nudged by -1, 0 or +1 below
  logic [63:0] width_limits[4] = '{MAX_INT32, MAX_UINT32, MAX_INT64, MAX_UINT64};

  string good_suffixes[19] = '{"", "L", "l", "LL", "ll", "LU", "Lu", "lU", "lu", "U", "u",
                               "LLU", "LLu", "llU", "llu", "ULL", "Ull", "uLL", "ull"};
  string bad_suffixes[8] = '{"UL", "ul", "Ul", "lL", "Ll", "LLL", "UU", "x"};

  c_integer_literal_classifier DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver stalls at random, one draw per cycle
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // every handshake seen at the edge it happens, before the drivers' updates land
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) board.set_long_width(cfg_data);
      if (in_valid && in_ready) board.note_char(in_data);
      if (out_valid && out_ready) board.check_literal(out_data);
    end
  end

  // one character item; an idle gap may come first, valid then holds until taken
  task automatic push_char(input logic [7:0] ch, input logic last);
    int gap;
    gap = 0;
    while (gap < 12 && $urandom_range(99) < idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{character: ch, is_last: last};
    do @(posedge clk); while (!in_ready);
    chars_sent++;
  endtask

  task automatic send_literal(input text_t t);
    foreach (t[i]) push_char(t[i], i == t.size() - 1);
  endtask

  function automatic text_t to_text(input string s);
    text_t t;
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
    return t;
  endfunction

  function automatic logic [63:0] pick_magnitude(input int radix_sel);
    logic [63:0] v;
    case ($urandom_range(7))
      0, 1, 2: v = 64'($urandom_range(300));
      3:       v = 64'($urandom);
      4:       v = {$urandom, $urandom};
      default: v = width_limits[$urandom_range(3)] + 64'($urandom_range(2)) - 64'd1;
    endcase
    // binary text gets long, so keep most of it short
    if (radix_sel == 3 && $urandom_range(3) != 0) v = v & 64'hFFF;
    return v;
  endfunction

  // mostly well-formed literals with random content, some broken or pure noise
  function automatic text_t make_literal();
    text_t t;
    string s;
    string digs;
    string zeros;
    logic [63:0] v;
    int radix_sel;
    int roll;
    radix_sel = $urandom_range(3);
    v = pick_magnitude(radix_sel);
    zeros = "";
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) zeros = {zeros, "0"};
    case (radix_sel)
      0: s = $sformatf("%0d", v);
      1: begin
        digs = $sformatf("%0h", v);
        if ($urandom_range(1)) digs = digs.toupper();
        s = "0x";
        if ($urandom_range(1)) s = "0X";
        s = {s, zeros, digs};
      end
      2: s = {"0", zeros, $sformatf("%0o", v)};
      default: begin
        s = "0b";
        if ($urandom_range(1)) s = "0B";
        s = {s, zeros, $sformatf("%0b", v)};
      end
    endcase
    // extra digits on a big value push it past 64 bits
    if (v > MAX_INT64 && $urandom_range(2) == 0) repeat ($urandom_range(1, 3)) s = {s, "1"};
    if ($urandom_range(4) == 0) s = {s, bad_suffixes[$urandom_range(7)]};
    else s = {s, good_suffixes[$urandom_range(18)]};
    t = to_text(s);
    roll = $urandom_range(99);
    if (roll < 8) begin
      t.delete();
      repeat ($urandom_range(1, 5)) t.push_back(8'($urandom));
    end else if (roll < 16) begin
      t[$urandom_range(t.size() - 1)] = 8'($urandom_range(255));
    end else if (roll < 20) begin
      t.insert($urandom_range(t.size() - 1), 8'($urandom_range(255)));
    end
    return t;
  endfunction

  task automatic run_random(input int count);
    int start;
    start = chars_sent;
    while (chars_sent - start < count) send_literal(make_literal());
  endtask

  // drain every pending result, then wait out anything still in flight
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    for (int n = 0; n < 5000 && board.pending() != 0; n++) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_long_width(input logic wide);
    cfg_valid <= 1'b1;
    cfg_data <= wide;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed literals with long at 32 bits
    write_long_width(1'b0);
    send_literal(to_text("0"));        // lone zero
    send_literal(to_text("0u"));       // zero with a suffix
    send_literal(to_text("0x"));       // prefix with no digit
    send_literal(to_text("0b2"));      // binary prefix, digit outside the base
    send_literal(to_text("08"));       // octal digit out of range
    send_literal(to_text("-1"));       // no leading digit, rest ignored
    send_literal(to_text("9UL"));      // suffix spelling that is refused
    send_literal(to_text("0XFFllu"));
    send_literal(to_text("7L"));
    send_literal('{8'hFF});            // top character code
    send_literal('{8'h00});            // bottom character code

    // random literals, one idling pattern per phase, long width flipping between them
    run_random(100);
    settle();
    write_long_width(1'b1);
    idle_pct = 65;
    run_random(110);
    settle();
    write_long_width(1'b0);
    idle_pct = 0;
    stall_pct = 65;
    run_random(110);
    settle();
    write_long_width(1'b1);
    idle_pct = 21;
    stall_pct = 21;
    run_random(110);
    settle();
    write_long_width(1'b0);
    idle_pct = 0;
    stall_pct = 0;
    run_random(90);
    settle();
    repeat (6) @(posedge clk);

    if (board.pending() != 0)
      board.report($sformatf("%0d literal results never arrived", board.pending()));
    $display("covered %0d characters in %0d literals, long at 32 and 64 bits",
             chars_sent, board.checked);
    $display("idling: none, sender 65%%, receiver 65%%, both 21%%");
    if (board.errors == 0) begin
      $display("PASS c_integer_literal_classifier");
    end else begin
      $display("FAIL c_integer_literal_classifier");
    end
    $finish;
  end

  // watchdog far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("timeout with %0d literal results pending", board.pending());
    $display("FAIL c_integer_literal_classifier");
    $finish;
  end

endmodule
